[sv/robs_pkg.sv]
// Shared widths, constants and types of the ray against oriented box slab test.
package robs_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int AXIS_W    = 18;
    localparam int HALF_W    = COORD_W - 1;
    localparam int CFG_IDX_W = 3;

    localparam int P_W    = COORD_W + 1;
    localparam int PROD_W = AXIS_W + P_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int E_W    = ACC_W - FRAC_W;
    localparam int NUM_W  = E_W + 1;
    localparam int DEN_W  = E_W;
    localparam int MAG_W  = NUM_W;
    localparam int FULL_W = MAG_W + FRAC_W;
    localparam int HI_W   = FULL_W - COORD_W;
    localparam int WIDE_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W  = $clog2(COORD_W);
    localparam int STEP_W = 3;
    localparam int SLAB_W = 2;

    localparam logic signed [E_W-1:0] EPS_POS = E_W'(((1 << FRAC_W) + 500) / 1000);
    localparam logic signed [E_W-1:0] EPS_NEG = -EPS_POS;

    localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    localparam logic [STEP_W-1:0] MAC_LAST    = STEP_W'(5);
    localparam logic [STEP_W-1:0] MAC_F_FIRST = STEP_W'(3);
    localparam logic [SLAB_W-1:0] SLAB_LAST   = SLAB_W'(2);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [AXIS_W-1:0]  t_axis;
    typedef logic        [HALF_W-1:0]  t_half;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic sel_f;
        logic first;
    } t_mac_ctl;

endpackage

[sv/robs_slab_if.sv]
// Handshake channel that carries one slab word into the block.
interface robs_slab_if;
    import robs_pkg::*;

    logic   valid;
    logic   ready;
    t_coord center_x;
    t_coord center_y;
    t_coord center_z;
    t_axis  axis_x;
    t_axis  axis_y;
    t_axis  axis_z;
    t_half  half_extent;

    modport source (
        output valid, center_x, center_y, center_z, axis_x, axis_y, axis_z, half_extent,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, center_z, axis_x, axis_y, axis_z, half_extent,
        output ready
    );
endinterface

[sv/robs_result_if.sv]
// Handshake channel that carries one hit result word out of the block.
interface robs_result_if;
    import robs_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    t_coord distance;

    modport source (
        output valid, hit, distance,
        input  ready
    );

    modport sink (
        input  valid, hit, distance,
        output ready
    );
endinterface

[sv/robs_mac.sv]
// Shared multiplier with registered product and two dot product accumulators.
module robs_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  robs_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [robs_pkg::AXIS_W-1:0]   i_a,
    input  logic signed [robs_pkg::P_W-1:0]      i_b,
    output logic signed [robs_pkg::ACC_W-1:0]    o_acc_e,
    output logic signed [robs_pkg::ACC_W-1:0]    o_acc_f
);
    import robs_pkg::*;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc_e;
    logic signed [ACC_W-1:0]  r_acc_f;
    logic signed [ACC_W-1:0]  n_acc_e;
    logic signed [ACC_W-1:0]  n_acc_f;
    logic signed [ACC_W-1:0]  prod_ext;

    assign n_prod   = i_a * i_b;
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc_e = r_acc_e;
        n_acc_f = r_acc_f;
        if (r_ctl.valid) begin
            if (r_ctl.sel_f) begin
                n_acc_f = r_ctl.first ? prod_ext : r_acc_f + prod_ext;
            end else begin
                n_acc_e = r_ctl.first ? prod_ext : r_acc_e + prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod  <= n_prod;
        r_acc_e <= n_acc_e;
        r_acc_f <= n_acc_f;
    end

    assign o_acc_e = r_acc_e;
    assign o_acc_f = r_acc_f;
endmodule

[sv/robs_div.sv]
// Two lane restoring divider with a shared divisor and saturated signed quotients.
module robs_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [robs_pkg::NUM_W-1:0]     i_num_a,
    input  logic signed [robs_pkg::NUM_W-1:0]     i_num_b,
    input  logic signed [robs_pkg::DEN_W-1:0]     i_den,
    output logic                                  o_done,
    output logic signed [robs_pkg::COORD_W-1:0]   o_quo_a,
    output logic signed [robs_pkg::COORD_W-1:0]   o_quo_b
);
    import robs_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE,
        D_ABS,
        D_OVF,
        D_ITER,
        D_DONE
    } t_div_state;

    t_div_state               r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_done, n_done;
    logic signed [NUM_W-1:0]  r_num [2];
    logic signed [NUM_W-1:0]  n_num [2];
    logic signed [DEN_W-1:0]  r_den, n_den;
    logic [MAG_W-1:0]         r_mag [2];
    logic [MAG_W-1:0]         n_mag [2];
    logic [DEN_W-1:0]         r_dmag, n_dmag;
    logic                     r_neg [2];
    logic                     n_neg [2];
    logic                     r_ovf [2];
    logic                     n_ovf [2];
    logic [DEN_W-1:0]         r_rem [2];
    logic [DEN_W-1:0]         n_rem [2];
    logic [COORD_W-1:0]       r_low [2];
    logic [COORD_W-1:0]       n_low [2];
    logic signed [COORD_W-1:0] r_quo [2];
    logic signed [COORD_W-1:0] n_quo [2];
    logic [FULL_W-1:0]        full [2];
    logic [WIDE_W-1:0]        hi_wide [2];
    logic [DEN_W+1:0]         rem2 [2];
    logic [DEN_W+1:0]         diff [2];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_den   = r_den;
        n_dmag  = r_dmag;
        for (int l = 0; l < 2; l++) begin
            n_num[l]   = r_num[l];
            n_mag[l]   = r_mag[l];
            n_neg[l]   = r_neg[l];
            n_ovf[l]   = r_ovf[l];
            n_rem[l]   = r_rem[l];
            n_low[l]   = r_low[l];
            n_quo[l]   = r_quo[l];
            full[l]    = {r_mag[l], {FRAC_W{1'b0}}};
            hi_wide[l] = WIDE_W'(full[l][FULL_W-1:COORD_W]);
            rem2[l]    = {1'b0, r_rem[l], r_low[l][COORD_W-1]};
            diff[l]    = rem2[l] - {2'b00, r_dmag};
        end

        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_num[0] = i_num_a;
                    n_num[1] = i_num_b;
                    n_den    = i_den;
                    n_state  = D_ABS;
                end
            end
            D_ABS: begin
                n_dmag = r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
                for (int l = 0; l < 2; l++) begin
                    n_neg[l] = r_num[l][NUM_W-1] ^ r_den[DEN_W-1];
                    n_mag[l] = r_num[l][NUM_W-1] ? MAG_W'(-r_num[l]) : MAG_W'(r_num[l]);
                end
                n_state = D_OVF;
            end
            D_OVF: begin
                for (int l = 0; l < 2; l++) begin
                    n_ovf[l] = hi_wide[l] >= WIDE_W'(r_dmag);
                    n_rem[l] = hi_wide[l][DEN_W-1:0];
                    n_low[l] = full[l][COORD_W-1:0];
                end
                n_cnt   = CNT_W'(COORD_W - 1);
                n_state = D_ITER;
            end
            D_ITER: begin
                for (int l = 0; l < 2; l++) begin
                    if (!diff[l][DEN_W+1]) begin
                        n_rem[l] = diff[l][DEN_W-1:0];
                        n_low[l] = {r_low[l][COORD_W-2:0], 1'b1};
                    end else begin
                        n_rem[l] = rem2[l][DEN_W-1:0];
                        n_low[l] = {r_low[l][COORD_W-2:0], 1'b0};
                    end
                end
                if (r_cnt == '0) begin
                    n_state = D_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            D_DONE: begin
                for (int l = 0; l < 2; l++) begin
                    if (r_ovf[l]) begin
                        n_quo[l] = r_neg[l] ? DIST_MIN : DIST_MAX;
                    end else if (!r_neg[l]) begin
                        n_quo[l] = r_low[l][COORD_W-1] ? DIST_MAX : signed'(r_low[l]);
                    end else if (r_low[l][COORD_W-1] && (|r_low[l][COORD_W-2:0])) begin
                        n_quo[l] = DIST_MIN;
                    end else begin
                        n_quo[l] = -signed'(r_low[l]);
                    end
                end
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_den  <= n_den;
        r_dmag <= n_dmag;
        for (int l = 0; l < 2; l++) begin
            r_num[l] <= n_num[l];
            r_mag[l] <= n_mag[l];
            r_neg[l] <= n_neg[l];
            r_ovf[l] <= n_ovf[l];
            r_rem[l] <= n_rem[l];
            r_low[l] <= n_low[l];
            r_quo[l] <= n_quo[l];
        end
    end

    assign o_done  = r_done;
    assign o_quo_a = r_quo[0];
    assign o_quo_b = r_quo[1];

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == D_IDLE)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");
    a_done_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state == D_DONE) && $past(r_state, 2) == D_ITER)
        else $error("divider finished without its iteration steps");
`endif
endmodule

[sv/ray_obb_slab_intersect_unit.sv]
// Top level of the ray against oriented box slab test with its slab sequencer.
// A slab word that follows a miss in the same box skips the multiplier and the divider,
// and a slab parallel to the ray skips the divider; the third slab of a box also passes
// through a finish state to place the result word. Most of the time goes to the shared
// divider, which forms one quotient bit per cycle for both slab bounds at once over 32
// steps, after the two dot products on the single shared multiplier. The user must write
// the ray through the register port only while no slab is in flight; the block itself
// does not enforce this. Results are held in an output register so that the next slab
// is accepted while a result waits.
module ray_obb_slab_intersect_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [robs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [robs_pkg::COORD_W-1:0]         i_cfg_data,
    robs_slab_if.sink                            i_slab,
    robs_result_if.source                        o_result
);
    import robs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_PREP,
        S_DIV,
        S_BOUND,
        S_CHECK,
        S_ADV,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    t_coord              r_org_x, r_org_y, r_org_z, n_org_x, n_org_y, n_org_z;
    t_coord              r_dir_x, r_dir_y, r_dir_z, n_dir_x, n_dir_y, n_dir_z;
    logic signed [P_W-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    t_axis               r_ax, r_ay, r_az, n_ax, n_ay, n_az;
    t_half               r_h, n_h;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SLAB_W-1:0]   r_slab_idx, n_slab_idx;
    t_coord              r_near, r_far, n_near, n_far;
    logic                r_missed, n_missed;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    t_coord              r_out_dist, n_out_dist;

    t_cfg_idx            cfg_idx;
    logic                accept;
    logic                out_free;
    t_mac_ctl            mac_ctl;
    logic signed [AXIS_W-1:0] mac_a;
    logic signed [P_W-1:0]    mac_b;
    logic signed [ACC_W-1:0]  acc_e, acc_f;
    logic signed [E_W-1:0]    e_val, f_val;
    logic signed [NUM_W-1:0]  e_ext, h_ext, num_a, num_b;
    logic                     div_start, div_done;
    t_coord                   quo_a, quo_b, t_lo, t_hi, dist_sel;
    logic                     hit_sel;

    assign cfg_idx  = t_cfg_idx'(i_cfg_idx);
    assign accept   = i_slab.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_result.ready;

    assign e_val = acc_e[ACC_W-1:FRAC_W];
    assign f_val = acc_f[ACC_W-1:FRAC_W];
    assign e_ext = NUM_W'(e_val);
    assign h_ext = signed'(NUM_W'(r_h));
    assign num_a = e_ext + h_ext;
    assign num_b = e_ext - h_ext;

    assign t_lo = (quo_a < quo_b) ? quo_a : quo_b;
    assign t_hi = (quo_a < quo_b) ? quo_b : quo_a;

    assign dist_sel = (r_near > 0) ? r_near : r_far;
    assign hit_sel  = !r_missed && (dist_sel != DIST_MAX);

    always_comb begin
        mac_ctl.valid = (r_state == S_MAC);
        mac_ctl.sel_f = (r_step >= MAC_F_FIRST);
        mac_ctl.first = (r_step == '0) || (r_step == MAC_F_FIRST);
        case (r_step)
            3'd0: begin mac_a = r_ax; mac_b = r_px; end
            3'd1: begin mac_a = r_ay; mac_b = r_py; end
            3'd2: begin mac_a = r_az; mac_b = r_pz; end
            3'd3: begin mac_a = r_ax; mac_b = P_W'(r_dir_x); end
            3'd4: begin mac_a = r_ay; mac_b = P_W'(r_dir_y); end
            3'd5: begin mac_a = r_az; mac_b = P_W'(r_dir_z); end
            default: begin mac_a = '0; mac_b = '0; end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_org_x     = r_org_x;
        n_org_y     = r_org_y;
        n_org_z     = r_org_z;
        n_dir_x     = r_dir_x;
        n_dir_y     = r_dir_y;
        n_dir_z     = r_dir_z;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_az        = r_az;
        n_h         = r_h;
        n_step      = r_step;
        n_slab_idx  = r_slab_idx;
        n_near      = r_near;
        n_far       = r_far;
        n_missed    = r_missed;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_hit   = r_out_hit;
        n_out_dist  = r_out_dist;
        div_start   = 1'b0;

        if (i_cfg_we) begin
            unique case (cfg_idx)
                CFG_ORIGIN_X: n_org_x = signed'(i_cfg_data);
                CFG_ORIGIN_Y: n_org_y = signed'(i_cfg_data);
                CFG_ORIGIN_Z: n_org_z = signed'(i_cfg_data);
                CFG_DIR_X:    n_dir_x = signed'(i_cfg_data);
                CFG_DIR_Y:    n_dir_y = signed'(i_cfg_data);
                CFG_DIR_Z:    n_dir_z = signed'(i_cfg_data);
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_px   = P_W'(i_slab.center_x) - P_W'(r_org_x);
                    n_py   = P_W'(i_slab.center_y) - P_W'(r_org_y);
                    n_pz   = P_W'(i_slab.center_z) - P_W'(r_org_z);
                    n_ax   = i_slab.axis_x;
                    n_ay   = i_slab.axis_y;
                    n_az   = i_slab.axis_z;
                    n_h    = i_slab.half_extent;
                    n_step = '0;
                    n_state = r_missed ? S_ADV : S_MAC;
                end
            end
            S_MAC: begin
                if (r_step == MAC_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAIN: n_state = S_PREP;
            S_PREP: begin
                if ((f_val > EPS_POS) || (f_val < EPS_NEG)) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    if ((e_ext < -h_ext) || (e_ext > h_ext)) begin
                        n_missed = 1'b1;
                    end
                    n_state = S_ADV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                if (t_lo > r_near) begin
                    n_near = t_lo;
                end
                if (t_hi < r_far) begin
                    n_far = t_hi;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((r_near > r_far) || r_far[COORD_W-1]) begin
                    n_missed = 1'b1;
                end
                n_state = S_ADV;
            end
            S_ADV: begin
                if (r_slab_idx == SLAB_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_slab_idx = r_slab_idx + 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = hit_sel;
                    n_out_dist  = hit_sel ? dist_sel : DIST_MAX;
                    n_slab_idx  = '0;
                    n_near      = DIST_MIN;
                    n_far       = DIST_MAX;
                    n_missed    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_dir_z     <= '0;
            r_step      <= '0;
            r_slab_idx  <= '0;
            r_near      <= DIST_MIN;
            r_far       <= DIST_MAX;
            r_missed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_org_x     <= n_org_x;
            r_org_y     <= n_org_y;
            r_org_z     <= n_org_z;
            r_dir_x     <= n_dir_x;
            r_dir_y     <= n_dir_y;
            r_dir_z     <= n_dir_z;
            r_step      <= n_step;
            r_slab_idx  <= n_slab_idx;
            r_near      <= n_near;
            r_far       <= n_far;
            r_missed    <= n_missed;
            r_out_valid <= n_out_valid;
        end
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_az       <= n_az;
        r_h        <= n_h;
        r_out_hit  <= n_out_hit;
        r_out_dist <= n_out_dist;
    end

    robs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc_e (acc_e),
        .o_acc_f (acc_f)
    );

    robs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_a (num_a),
        .i_num_b (num_b),
        .i_den   (f_val),
        .o_done  (div_done),
        .o_quo_a (quo_a),
        .o_quo_b (quo_b)
    );

    assign i_slab.ready      = (r_state == S_IDLE);
    assign o_result.valid    = r_out_valid;
    assign o_result.hit      = r_out_hit;
    assign o_result.distance = r_out_dist;

`ifndef SYNTH
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result word raised outside the box end");
    a_hit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> (r_out_dist != DIST_MAX))
        else $error("hit reported with an unbounded distance");
    a_box_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=>
            (r_near == DIST_MIN && r_far == DIST_MAX && !r_missed && r_slab_idx == '0))
        else $error("box state not cleared after its result");
    a_no_div_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !r_missed)
        else $error("divider started for a box that has already missed");
`endif
endmodule
